>>> design/separating_axis_overlap_unit_defines.svh
// Assertion macros for the checker file.
`ifndef SEPARATING_AXIS_OVERLAP_UNIT_DEFINES_SVH
`define SEPARATING_AXIS_OVERLAP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define SAO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define SAO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sao_pkg.sv
package sao_pkg;

  localparam int MAX_VERTS = 16;
  localparam int MAX_AXES  = 16;

  // Index and count widths derived from the store depths.
  localparam int VW  = $clog2(MAX_VERTS);
  localparam int VCW = $clog2(MAX_VERTS + 1);
  localparam int AW  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int ACW = $clog2(MAX_AXES + 1);
  localparam int KW  = $clog2(2 * MAX_AXES + 1);

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_VERT_A = 3'd0,
    REQ_VERT_B = 3'd1,
    REQ_AXIS_A = 3'd2,
    REQ_AXIS_B = 3'd3,
    REQ_EVAL   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic               collides;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [32:0]        overlap_depth;
    logic               load_dropped;
  } out_word_t;

  // Running projection record handed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] ax_x;
    logic signed [15:0] ax_y;
    logic               a_seen;
    logic signed [32:0] a_min;
    logic signed [32:0] a_max;
    logic               b_seen;
    logic signed [32:0] b_min;
    logic signed [32:0] b_max;
  } proj_rec_t;

  // Per-cell load and enable controls.
  typedef struct packed {
    logic               wr_a;
    logic               wr_b;
    logic               act_a;
    logic               act_b;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } cell_ctl_t;

  // Accumulator results seen by the sequencer.
  typedef struct packed {
    logic               hit;
    logic signed [15:0] best_x;
    logic signed [15:0] best_y;
    logic [32:0]        best_depth;
    logic [KW-1:0]      done_cnt;
  } acc_stat_t;

endpackage

>>> design/sao_cell.sv
module sao_cell (
  input  logic               clk,
  input  logic               rst,
  input  sao_pkg::cell_ctl_t ctl,
  input  sao_pkg::proj_rec_t rec_in,
  output sao_pkg::proj_rec_t rec_out
);

  logic signed [15:0] ax, ay, bx, by;
  logic signed [31:0] pax, pay, pbx, pby;
  logic signed [32:0] dot_a, dot_b;
  sao_pkg::proj_rec_t rec_next;

  // One vertex of each polygon lives in this cell.
  always_ff @(posedge clk) begin
    if (ctl.wr_a) begin
      ax <= ctl.x;
      ay <= ctl.y;
    end
    if (ctl.wr_b) begin
      bx <= ctl.x;
      by <= ctl.y;
    end
  end

  // Project both vertices onto the passing axis.
  always_comb begin
    pax = 32'(rec_in.ax_x) * 32'(ax);
    pay = 32'(rec_in.ax_y) * 32'(ay);
    pbx = 32'(rec_in.ax_x) * 32'(bx);
    pby = 32'(rec_in.ax_y) * 32'(by);
    dot_a = {pax[31], pax} + {pay[31], pay};
    dot_b = {pbx[31], pbx} + {pby[31], pby};
  end

  // Fold this cell's projections into the running interval.
  always_comb begin
    rec_next = rec_in;
    if (ctl.act_a) begin
      if (!rec_in.a_seen || (dot_a < $signed(rec_in.a_min))) rec_next.a_min = dot_a;
      if (!rec_in.a_seen || (dot_a > $signed(rec_in.a_max))) rec_next.a_max = dot_a;
      rec_next.a_seen = 1'b1;
    end
    if (ctl.act_b) begin
      if (!rec_in.b_seen || (dot_b < $signed(rec_in.b_min))) rec_next.b_min = dot_b;
      if (!rec_in.b_seen || (dot_b > $signed(rec_in.b_max))) rec_next.b_max = dot_b;
      rec_next.b_seen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out.valid <= 1'b0;
    end else begin
      rec_out.valid <= rec_next.valid;
    end
    rec_out.ax_x   <= rec_next.ax_x;
    rec_out.ax_y   <= rec_next.ax_y;
    rec_out.a_seen <= rec_next.a_seen;
    rec_out.a_min  <= rec_next.a_min;
    rec_out.a_max  <= rec_next.a_max;
    rec_out.b_seen <= rec_next.b_seen;
    rec_out.b_min  <= rec_next.b_min;
    rec_out.b_max  <= rec_next.b_max;
  end

endmodule

>>> design/sao_accum.sv
module sao_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sao_pkg::proj_rec_t rec,
  output sao_pkg::acc_stat_t stat
);

  logic               have;
  logic               sep;
  logic signed [32:0] lo_max, hi_min;
  logic signed [33:0] depth_full;
  logic [32:0]        depth;

  // Separation test and overlap of the two intervals.
  always_comb begin
    sep = !rec.a_seen || !rec.b_seen ||
          ($signed(rec.a_min) > $signed(rec.b_max)) ||
          ($signed(rec.b_min) > $signed(rec.a_max));
    lo_max = ($signed(rec.a_max) < $signed(rec.b_max)) ? rec.a_max : rec.b_max;
    hi_min = ($signed(rec.a_min) > $signed(rec.b_min)) ? rec.a_min : rec.b_min;
    depth_full = {lo_max[32], lo_max} - {hi_min[32], hi_min};
    depth = depth_full[32:0];
  end

  // Axes arrive in load order; the first separation freezes the answer.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      stat.hit      <= 1'b1;
      have          <= 1'b0;
      stat.done_cnt <= '0;
    end else if (rec.valid) begin
      stat.done_cnt <= stat.done_cnt + 1'b1;
      if (stat.hit) begin
        if (sep) begin
          stat.hit <= 1'b0;
        end else if (!have || (depth < stat.best_depth)) begin
          have            <= 1'b1;
          stat.best_depth <= depth;
          stat.best_x     <= rec.ax_x;
          stat.best_y     <= rec.ax_y;
        end
      end
    end
    if (start) begin
      stat.best_depth <= '0;
      stat.best_x     <= '0;
      stat.best_y     <= '0;
    end
  end

endmodule

>>> design/separating_axis_overlap_unit.sv
// Loads are accepted back to back, one per cycle while idle; they give no result word.
// An evaluate feeds the loaded axes into the vertex cell chain one per cycle, after the
// axis store read register; each axis crosses all MAX_VERTS cells and the accumulator,
// while the control waits in drain for the last axis and then gives the result from done.
// Input is stalled during an evaluate; the result waits in an output register.
// Synchronous active-high reset clears the fill counts, the drop flag and all valids.
module separating_axis_overlap_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sao_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sao_pkg::out_word_t  out_word
);

  sao_pkg::state_t state, state_next;

  logic [sao_pkg::VCW-1:0] cnt_va, cnt_vb;
  logic [sao_pkg::ACW-1:0] cnt_xa, cnt_xb;
  logic                    drop;
  logic [sao_pkg::KW-1:0]  k, total;
  logic                    acc_in, issue, start, finish;
  logic                    ld_va, ld_vb, ld_xa, ld_xb, eval_acc;

  logic [31:0] axes_first  [sao_pkg::MAX_AXES];
  logic [31:0] axes_second [sao_pkg::MAX_AXES];
  logic [31:0] rd_a, rd_b;
  logic        rd_sel_a, feed_valid;
  logic [sao_pkg::KW-1:0] k_off;

  sao_pkg::proj_rec_t chain [sao_pkg::MAX_VERTS + 1];
  sao_pkg::acc_stat_t stat;

  // Input decode.
  assign acc_in   = in_valid && in_ready;
  assign ld_va    = acc_in && (in_word.req_type == sao_pkg::REQ_VERT_A);
  assign ld_vb    = acc_in && (in_word.req_type == sao_pkg::REQ_VERT_B);
  assign ld_xa    = acc_in && (in_word.req_type == sao_pkg::REQ_AXIS_A);
  assign ld_xb    = acc_in && (in_word.req_type == sao_pkg::REQ_AXIS_B);
  assign eval_acc = acc_in && (in_word.req_type == sao_pkg::REQ_EVAL);
  assign total    = sao_pkg::KW'(cnt_xa) + sao_pkg::KW'(cnt_xb);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sao_pkg::ST_IDLE:  if (eval_acc) state_next = sao_pkg::ST_FEED;
      sao_pkg::ST_FEED:  if (k >= total) state_next = sao_pkg::ST_DRAIN;
      sao_pkg::ST_DRAIN: if (stat.done_cnt == total) state_next = sao_pkg::ST_DONE;
      sao_pkg::ST_DONE:  if (!out_valid || out_ready) state_next = sao_pkg::ST_IDLE;
      default:           state_next = sao_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    finish   = 1'b0;
    unique case (state)
      sao_pkg::ST_IDLE:  in_ready = 1'b1;
      sao_pkg::ST_FEED:  issue = (k < total);
      sao_pkg::ST_DRAIN: ;
      sao_pkg::ST_DONE:  finish = !out_valid || out_ready;
      default:           ;
    endcase
  end

  assign start = eval_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sao_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill counts and drop flag.
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      cnt_va <= '0;
      cnt_vb <= '0;
      cnt_xa <= '0;
      cnt_xb <= '0;
      drop   <= 1'b0;
    end else begin
      if (ld_va) begin
        if (cnt_va < sao_pkg::VCW'(sao_pkg::MAX_VERTS)) cnt_va <= cnt_va + 1'b1;
        else drop <= 1'b1;
      end
      if (ld_vb) begin
        if (cnt_vb < sao_pkg::VCW'(sao_pkg::MAX_VERTS)) cnt_vb <= cnt_vb + 1'b1;
        else drop <= 1'b1;
      end
      if (ld_xa) begin
        if (cnt_xa < sao_pkg::ACW'(sao_pkg::MAX_AXES)) cnt_xa <= cnt_xa + 1'b1;
        else drop <= 1'b1;
      end
      if (ld_xb) begin
        if (cnt_xb < sao_pkg::ACW'(sao_pkg::MAX_AXES)) cnt_xb <= cnt_xb + 1'b1;
        else drop <= 1'b1;
      end
    end
  end

  // Axis stores, written at the fill count and read by the feed counter.
  assign k_off = k - sao_pkg::KW'(cnt_xa);

  always_ff @(posedge clk) begin
    if (ld_xa && (cnt_xa < sao_pkg::ACW'(sao_pkg::MAX_AXES))) begin
      axes_first[cnt_xa[sao_pkg::AW-1:0]] <= {in_word.coord_y, in_word.coord_x};
    end
    if (ld_xb && (cnt_xb < sao_pkg::ACW'(sao_pkg::MAX_AXES))) begin
      axes_second[cnt_xb[sao_pkg::AW-1:0]] <= {in_word.coord_y, in_word.coord_x};
    end
    rd_a <= axes_first[k[sao_pkg::AW-1:0]];
    rd_b <= axes_second[k_off[sao_pkg::AW-1:0]];
    rd_sel_a <= (k < sao_pkg::KW'(cnt_xa));
  end

  // Feed counter.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      k <= '0;
    end else if (issue) begin
      k <= k + 1'b1;
    end
    if (rst) begin
      feed_valid <= 1'b0;
    end else begin
      feed_valid <= issue;
    end
  end

  // Head of the chain: an axis with empty intervals.
  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = feed_valid;
    chain[0].ax_x   = rd_sel_a ? rd_a[15:0]  : rd_b[15:0];
    chain[0].ax_y   = rd_sel_a ? rd_a[31:16] : rd_b[31:16];
  end

  // Vertex cell chain.
  for (genvar i = 0; i < sao_pkg::MAX_VERTS; i++) begin : g_cell
    sao_pkg::cell_ctl_t ctl;
    always_comb begin
      ctl.wr_a  = ld_va && (cnt_va < sao_pkg::VCW'(sao_pkg::MAX_VERTS)) &&
                  (cnt_va[sao_pkg::VW-1:0] == sao_pkg::VW'(i));
      ctl.wr_b  = ld_vb && (cnt_vb < sao_pkg::VCW'(sao_pkg::MAX_VERTS)) &&
                  (cnt_vb[sao_pkg::VW-1:0] == sao_pkg::VW'(i));
      ctl.act_a = (cnt_va > sao_pkg::VCW'(i));
      ctl.act_b = (cnt_vb > sao_pkg::VCW'(i));
      ctl.x     = in_word.coord_x;
      ctl.y     = in_word.coord_y;
    end
    sao_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .rec_in  (chain[i]),
      .rec_out (chain[i+1])
    );
  end

  sao_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .rec   (chain[sao_pkg::MAX_VERTS]),
    .stat  (stat)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (finish) begin
      out_word.collides      <= stat.hit;
      out_word.normal_x      <= stat.hit ? stat.best_x : 16'sd0;
      out_word.normal_y      <= stat.hit ? stat.best_y : 16'sd0;
      out_word.overlap_depth <= stat.hit ? stat.best_depth : 33'd0;
      out_word.load_dropped  <= drop;
    end
  end

endmodule

>>> design/sao_checker.sv
`include "separating_axis_overlap_unit_defines.svh"

module sao_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input sao_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_ready,
  input sao_pkg::out_word_t out_word
);

  // A stalled result word holds.
  `SAO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")

  // A separated result carries no normal and no depth.
  `SAO_ASSERT_NOW(a_sep_zero, out_valid && !out_word.collides, (out_word.normal_x == 16'sd0) && (out_word.normal_y == 16'sd0) && (out_word.overlap_depth == 33'd0), "separated result has nonzero normal or depth")

  // An accepted evaluate stalls the input side.
  `SAO_ASSERT_NEXT(a_eval_stall, in_valid && in_ready && (in_word.req_type == sao_pkg::REQ_EVAL), !in_ready, "input accepted right after evaluate")

endmodule

bind separating_axis_overlap_unit sao_checker u_sao_checker (.*);
